FILE: rtl/texel_format_to_rgba8_decoder_unit_assert.svh
// Assertion macros shared by the texel decoder RTL.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing in synthesis.
`ifndef TEXEL_FORMAT_TO_RGBA8_DECODER_UNIT_ASSERT_SVH
`define TEXEL_FORMAT_TO_RGBA8_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TFD_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tfd: same-cycle check failed");
// Next-cycle implication
`define TFD_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tfd: next-cycle check failed");
`else
`define TFD_ASSERT_IMP(name, ck, rs, ante, cons)
`define TFD_ASSERT_NXT(name, ck, rs, ante, cons)
`endif

`endif

FILE: rtl/tfd_pkg.sv
package tfd_pkg;

  // Format byte codes
  localparam logic [7:0] FMT_RGBA16_A = 8'h00;
  localparam logic [7:0] FMT_RGBA16_B = 8'h08;
  localparam logic [7:0] FMT_RGBA16_C = 8'h10;
  localparam logic [7:0] FMT_CI4_A    = 8'h40;
  localparam logic [7:0] FMT_CI4_B    = 8'h50;
  localparam logic [7:0] FMT_CI8      = 8'h48;
  localparam logic [7:0] FMT_IA4      = 8'h60;
  localparam logic [7:0] FMT_IA8      = 8'h68;
  localparam logic [7:0] FMT_IA16     = 8'h70;
  localparam logic [7:0] FMT_I4_A     = 8'h80;
  localparam logic [7:0] FMT_I4_B     = 8'h90;
  localparam logic [7:0] FMT_I8       = 8'h88;

  // Input command codes
  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_TEXEL     = 1'b1;

  // Opaque green for formats that are not decoded
  localparam logic [31:0] RGBA_BAD = 32'h00FF00FF;

  // Output queue depth and its count width
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  typedef enum logic [3:0] {
    K_RGBA16, K_CI4, K_CI8, K_IA4, K_IA8, K_IA16, K_I4, K_I8, K_BAD
  } texel_kind_t;

  typedef enum logic [1:0] {
    ST_FIRST  = 2'b01,
    ST_SECOND = 2'b10
  } front_state_t;

  // One texel slot on its way from the issue stage to the output queue
  typedef struct packed {
    logic        valid;
    logic        is_ci;
    logic        idx_ok;
    logic        last;
    logic [31:0] rgba;
  } slot_t;

  // One queued result word
  typedef struct packed {
    logic        last;
    logic [31:0] rgba;
  } out_word_t;

  function automatic texel_kind_t decode_kind(input logic [7:0] fmt);
    texel_kind_t k;
    case (fmt)
      FMT_RGBA16_A, FMT_RGBA16_B, FMT_RGBA16_C: k = K_RGBA16;
      FMT_CI4_A, FMT_CI4_B:                     k = K_CI4;
      FMT_CI8:                                  k = K_CI8;
      FMT_IA4:                                  k = K_IA4;
      FMT_IA8:                                  k = K_IA8;
      FMT_IA16:                                 k = K_IA16;
      FMT_I4_A, FMT_I4_B:                       k = K_I4;
      FMT_I8:                                   k = K_I8;
      default:                                  k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic logic two_texel(input texel_kind_t k);
    return (k == K_CI4) || (k == K_IA4) || (k == K_I4);
  endfunction

  // RGBA5551 to RGBA8 packed R,G,B,A from the top byte down; low color bits zero, alpha bit replicated
  function automatic logic [31:0] expand_5551(input logic [15:0] v);
    return {v[15:11], 3'b000, v[10:6], 3'b000, v[5:1], 3'b000, {8{v[0]}}};
  endfunction

  function automatic logic [31:0] gray(input logic [7:0] i, input logic [7:0] a);
    return {i, i, i, a};
  endfunction

  // Texel value for every format that needs no palette
  function automatic logic [31:0] plain_texel(input texel_kind_t k,
                                              input logic [15:0] w,
                                              input logic second);
    logic [3:0]  nib;
    logic [31:0] t;
    nib = second ? w[3:0] : w[7:4];
    case (k)
      K_RGBA16: t = expand_5551(w);
      K_IA4:    t = gray({nib[3:1], 5'b00000}, {8{nib[0]}});
      K_IA8:    t = gray({w[7:1], 1'b0}, {8{w[0]}});
      K_IA16:   t = gray(w[15:8], w[7:0]);
      K_I4:     t = gray({nib, 4'b0000}, 8'hFF);
      K_I8:     t = gray(w[7:0], 8'hFF);
      K_CI4, K_CI8: t = '0;
      default:  t = RGBA_BAD;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/texel_format_to_rgba8_decoder_unit.sv
// Texel decoder: each 24-bit input word is a palette write (tuser = 0:
// RGBA5551 stored as RGBA8 at palette_index) or a texel word (tuser = 1)
// decoded by the format byte written through cfg_we/cfg_wdata, which the
// user must write only while the block is idle; the block does not enforce
// this. One-texel formats and palette writes take one word per cycle while
// the queue has room; CI4, IA4 and I4 emit two texels and take no new word
// until the second issues, as every texel is one issue slot on the
// palette's single read port. Results wait in a four-word output queue, so
// the input keeps flowing while the output stalls until that queue fills.
// Palette entries must be written before they are looked up.
module texel_format_to_rgba8_decoder_unit
  import tfd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // format_code
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // palette_index[7:0], data_word[23:8]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic        m_axis_tlast
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  logic [7:0]         format_code;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  slot_t              slot;
  logic [OUTQ_CW-1:0] q_count;
  logic               room;
  out_word_t          push_word;
  out_word_t          out_word;

  // Format register
  always_ff @(posedge clk) begin
    if (rst) begin
      format_code <= '0;
    end else if (cfg_we) begin
      format_code <= cfg_wdata;
    end
  end

  // Issue only with a free queue entry for every texel in flight
  assign room = (q_count + OUTQ_CW'(slot.valid)) < OUTQ_CW'(OUTQ_DEPTH);

  tfd_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .format_code(format_code),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser),
    .in_index   (s_axis_tdata[7:0]),
    .in_word    (s_axis_tdata[23:8]),
    .room       (room),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .slot       (slot)
  );

  tfd_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Merge palette data into the slot; out-of-range lookups read as zero
  always_comb begin
    push_word.last = slot.last;
    if (slot.is_ci) begin
      push_word.rgba = slot.idx_ok ? ram_rdata : '0;
    end else begin
      push_word.rgba = slot.rgba;
    end
  end

  tfd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (slot.valid),
    .push_word(push_word),
    .count    (q_count),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_word (out_word)
  );

  // Repack R,G,B,A with red in the lowest byte
  assign m_axis_tdata = {out_word.rgba[7:0], out_word.rgba[15:8],
                         out_word.rgba[23:16], out_word.rgba[31:24]};
  assign m_axis_tlast = out_word.last;

endmodule

FILE: rtl/tfd_ram.sv
module tfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tfd_front.sv
`include "texel_format_to_rgba8_decoder_unit_assert.svh"

module tfd_front
  import tfd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       format_code,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [7:0]                       in_index,
  input  logic [15:0]                      in_word,
  input  logic                             room,
  output logic                             ram_we,
  output logic [$clog2(PALETTE_DEPTH)-1:0] ram_waddr,
  output logic [31:0]                      ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(PALETTE_DEPTH)-1:0] ram_raddr,
  output slot_t                            slot
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  front_state_t state;
  front_state_t state_next;
  texel_kind_t  hold_kind;
  logic [7:0]   hold_byte;

  logic         accept;
  logic         issue;
  logic         second;
  texel_kind_t  kind_cur;
  logic [15:0]  word_cur;
  logic [3:0]   nib;
  logic [7:0]   idx8;
  logic         idx_ok;
  logic         is_ci;
  logic         wr_ok;

  // Handshake: new words only in the first slot and with queue room
  assign in_ready = (state == ST_FIRST) && room;
  assign accept   = in_valid && in_ready;
  assign second   = (state == ST_SECOND);

  // Select the slot source: incoming word or the held low byte
  assign kind_cur = second ? hold_kind : decode_kind(format_code);
  assign word_cur = second ? {8'h00, hold_byte} : in_word;
  assign nib      = second ? word_cur[3:0] : word_cur[7:4];
  assign idx8     = (kind_cur == K_CI8) ? word_cur[7:0] : {4'h0, nib};
  assign idx_ok   = ({1'b0, idx8} < 9'(PALETTE_DEPTH));
  assign is_ci    = (kind_cur == K_CI4) || (kind_cur == K_CI8);

  assign issue = second ? room : (accept && (in_command == CMD_TEXEL));

  // Palette write port
  assign wr_ok     = ({1'b0, in_index} < 9'(PALETTE_DEPTH));
  assign ram_we    = accept && (in_command == CMD_PAL_WRITE) && wr_ok;
  assign ram_waddr = in_index[IW-1:0];
  assign ram_wdata = expand_5551(in_word);

  // Palette read port, data lines up with the slot register
  assign ram_re    = issue && is_ci && idx_ok;
  assign ram_raddr = idx8[IW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FIRST: begin
        if (accept && (in_command == CMD_TEXEL) && two_texel(kind_cur)) begin
          state_next = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (room) begin
          state_next = ST_FIRST;
        end
      end
      default: state_next = ST_FIRST;
    endcase
  end

  // Advance the state and load the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FIRST;
      slot.valid <= 1'b0;
    end else begin
      state      <= state_next;
      slot.valid <= issue;
      if (issue) begin
        slot.is_ci  <= is_ci;
        slot.idx_ok <= idx_ok;
        slot.last   <= second || !two_texel(kind_cur);
        slot.rgba   <= plain_texel(kind_cur, word_cur, second);
      end
    end
  end

  // Hold the low byte for the second nibble
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_kind <= kind_cur;
      hold_byte <= in_word[7:0];
    end
  end

  `TFD_ASSERT_NXT(a_pair_enters_second, clk, rst,
    accept && (in_command == CMD_TEXEL) && two_texel(kind_cur), state == ST_SECOND)
  `TFD_ASSERT_IMP(a_ram_ports_apart, clk, rst, ram_we, !ram_re)
  `TFD_ASSERT_IMP(a_state_onehot, clk, rst, 1'b1, $onehot(state))

endmodule

FILE: rtl/tfd_outq.sv
`include "texel_format_to_rgba8_decoder_unit_assert.svh"

module tfd_outq
  import tfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  out_word_t          push_word,
  output logic [OUTQ_CW-1:0] count,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_word
);

  out_word_t          entries [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  `TFD_ASSERT_IMP(a_no_push_when_full, clk, rst, push, count != OUTQ_CW'(OUTQ_DEPTH))
  `TFD_ASSERT_NXT(a_push_shows_word, clk, rst, push && (count == '0), out_valid)
  `TFD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= OUTQ_CW'(OUTQ_DEPTH))

endmodule

FILE: bench/texel_rgba_checker.sv
`timescale 1ns / 1ps

// Watch both streams and the format register, predict the texels of every
// accepted word and compare each texel word leaving the block in order.
module texel_rgba_checker
  import tfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // palette_index[7:0], data_word[23:8]
  input  logic        s_axis_tuser,  // command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          texels_owed
);

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } texel_t;

  texel_t      owed[$];
  logic [31:0] palette_rgba [256];  // R in the top byte, A in the bottom one
  logic [7:0]  fmt;
  int          errs;

  // RGBA5551 to RGBA8, low color bits left at zero, alpha from its one bit
  function automatic logic [31:0] rgba_from_5551(input logic [15:0] c);
    logic [31:0] v;
    v[31:24] = {c[15:11], 3'b000};
    v[23:16] = {c[10:6], 3'b000};
    v[15:8]  = {c[5:1], 3'b000};
    v[7:0]   = c[0] ? 8'hFF : 8'h00;
    return v;
  endfunction

  function automatic logic [31:0] mono(input logic [7:0] i, input logic [7:0] a);
    return {i, i, i, a};
  endfunction

  task automatic owe(input logic [31:0] v, input logic last);
    texel_t t;
    t.red   = v[31:24];
    t.green = v[23:16];
    t.blue  = v[15:8];
    t.alpha = v[7:0];
    t.last  = last;
    owed.push_back(t);
  endtask

  // Store a palette color or queue the texels of one word
  task automatic predict(input logic cmd, input logic [7:0] idx, input logic [15:0] w);
    logic [7:0] lo;
    logic [3:0] hn;
    logic [3:0] ln;
    lo = w[7:0];
    hn = lo[7:4];
    ln = lo[3:0];
    if (cmd == CMD_PAL_WRITE) begin
      palette_rgba[idx] = rgba_from_5551(w);
    end else begin
      case (fmt)
        FMT_RGBA16_A, FMT_RGBA16_B, FMT_RGBA16_C: owe(rgba_from_5551(w), 1'b1);
        FMT_CI4_A, FMT_CI4_B: begin
          owe(palette_rgba[hn], 1'b0);
          owe(palette_rgba[ln], 1'b1);
        end
        FMT_CI8: owe(palette_rgba[lo], 1'b1);
        FMT_IA4: begin
          owe(mono({hn[3:1], 5'b00000}, {8{hn[0]}}), 1'b0);
          owe(mono({ln[3:1], 5'b00000}, {8{ln[0]}}), 1'b1);
        end
        FMT_IA8:  owe(mono({lo[7:1], 1'b0}, {8{lo[0]}}), 1'b1);
        FMT_IA16: owe(mono(w[15:8], lo), 1'b1);
        FMT_I4_A, FMT_I4_B: begin
          owe(mono({hn, 4'b0000}, 8'hFF), 1'b0);
          owe(mono({ln, 4'b0000}, 8'hFF), 1'b1);
        end
        FMT_I8:  owe(mono(lo, 8'hFF), 1'b1);
        default: owe(RGBA_BAD, 1'b1);
      endcase
    end
  endtask

  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, seen);
    end
  endtask

  // Compare one output word against the oldest owed texel
  task automatic match_word(input logic [31:0] d, input logic l);
    texel_t want;
    if (owed.size() == 0) begin
      errs++;
      $display("%0t: unexpected texel, expected none, got %08h last %0b", $time, d, l);
    end else begin
      want = owed.pop_front();
      field_check("red", want.red, d[7:0]);
      field_check("green", want.green, d[15:8]);
      field_check("blue", want.blue, d[23:16]);
      field_check("alpha", want.alpha, d[31:24]);
      field_check("last", {7'd0, want.last}, {7'd0, l});
    end
  endtask

  // Retire outputs first, then take the register and the input word
  always @(posedge clk) begin
    if (rst) begin
      owed.delete();
      fmt  = 8'h00;
      errs = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) match_word(m_axis_tdata, m_axis_tlast);
      if (cfg_we) fmt = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        predict(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]);
    end
    mismatches  <= errs;
    texels_owed <= owed.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tfd_pkg::*;

  localparam int WORD_TARGET    = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 250;

  // Format bytes with no decode of their own
  localparam logic [7:0] FMT_RGBA32   = 8'h18;
  localparam logic [7:0] FMT_ALL_ONES = 8'hFF;

  localparam logic [7:0] FORMAT_MENU [14] = '{
    FMT_RGBA16_A, FMT_RGBA16_B, FMT_RGBA16_C, FMT_CI4_A, FMT_CI4_B, FMT_CI8,
    FMT_IA4, FMT_IA8, FMT_IA16, FMT_I4_A, FMT_I4_B, FMT_I8, FMT_RGBA32, FMT_ALL_ONES
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'h000000;  // palette_index[7:0], data_word[23:8]
  logic        s_axis_tuser = 1'b0;        // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic        m_axis_tlast;

  int          mismatches;
  int          texels_owed;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;
  logic [7:0]  fmt_now = 8'h00;

  // Palette entries written so far; lookups only go to these
  bit          pal_seen [256];
  logic [7:0]  pal_list[$];
  logic [3:0]  low_list[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  texel_format_to_rgba8_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  texel_rgba_checker texel_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .texels_owed   (texels_owed)
  );

  // Offer one word, maybe after a gap, and hold it until taken
  task automatic send_word(input logic cmd, input logic [7:0] idx, input logic [15:0] w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {w, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [15:0] c);
    send_word(CMD_PAL_WRITE, idx, c);
    if (!pal_seen[idx]) begin
      pal_seen[idx] = 1'b1;
      pal_list.push_back(idx);
      if (idx < 8'd16) low_list.push_back(idx[3:0]);
    end
  endtask

  task automatic send_texel(input logic [15:0] w);
    send_word(CMD_TEXEL, 8'($urandom_range(0, 255)), w);
  endtask

  // Drop valid and wait until every owed texel is out and the pipe is empty
  task automatic settle;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (texels_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic [7:0] code);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we  <= 1'b0;
    fmt_now = code;
  endtask

  // Texel bits for the current format; indexed formats hit written entries only
  function automatic logic [15:0] texel_word();
    logic [15:0] w;
    w = 16'($urandom);
    case (fmt_now)
      FMT_CI4_A, FMT_CI4_B: begin
        w[7:4] = low_list[$urandom_range(0, low_list.size() - 1)];
        w[3:0] = low_list[$urandom_range(0, low_list.size() - 1)];
      end
      FMT_CI8: w[7:0] = pal_list[$urandom_range(0, pal_list.size() - 1)];
      default: begin
        if ($urandom_range(0, 5) == 0) w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    endcase
    return w;
  endfunction

  // Output side: random stalls, one long hold-off on request
  initial begin : sink
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (hold_out && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int         phase;
    int         pick;
    int         n;
    logic [7:0] code;
    phase = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: palette extremes, then every format at its edges
    write_palette(8'd0, 16'hFFFF);
    write_palette(8'd15, 16'h0000);
    write_palette(8'd255, 16'hA5A4);
    set_format(FMT_RGBA16_A);
    send_texel(16'h0000);
    send_texel(16'hFFFF);
    set_format(FMT_RGBA16_B);
    send_texel(16'h8421);
    set_format(FMT_RGBA16_C);
    send_texel(16'h7BDE);
    set_format(FMT_CI4_A);
    send_texel(16'h00F0);
    send_texel(16'hFF0F);
    set_format(FMT_CI4_B);
    send_texel(16'h12FF);
    set_format(FMT_CI8);
    send_texel(16'h00FF);
    send_texel(16'hFF00);
    set_format(FMT_IA4);
    send_texel(16'h00FF);
    send_texel(16'hFF1E);
    set_format(FMT_IA8);
    send_texel(16'h00FE);
    send_texel(16'hFF01);
    set_format(FMT_IA16);
    send_texel(16'hFF00);
    send_texel(16'h00FF);
    set_format(FMT_I4_A);
    send_texel(16'h00F0);
    send_texel(16'hFF0F);
    set_format(FMT_I4_B);
    send_texel(16'h005A);
    set_format(FMT_I8);
    send_texel(16'h00FF);
    send_texel(16'hFF00);
    set_format(FMT_RGBA32);
    send_texel(16'hFFFF);
    set_format(FMT_ALL_ONES);
    send_texel(16'h0000);

    // Random phases, each under one format setting
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 14);
      code = (pick == 14) ? 8'($urandom_range(0, 255)) : FORMAT_MENU[pick];
      set_format(code);
      phase++;
      if (phase == 4) hold_out = 1'b1;
      if (words_sent >= WORD_TARGET - 120) calm = 1'b1;
      n = $urandom_range(12, 48);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0)
          write_palette($urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                             : 8'($urandom_range(0, 255)),
                        16'($urandom));
        else
          send_texel(texel_word());
      end
    end

    settle();
    if (mismatches == 0 && texels_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
